// ===== design/frns_pkg.sv =====
// frns_pkg: shared types, register indexes and saturation helpers for the
// firing-rate neuron step unit. No dependencies.
`default_nettype none

package frns_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_DTC      = 3'd0;
	localparam logic [2:0] CFG_LEAK     = 3'd1;
	localparam logic [2:0] CFG_BASE     = 3'd2;
	localparam logic [2:0] CFG_FMIN     = 3'd3;
	localparam logic [2:0] CFG_GAIN     = 3'd4;
	localparam logic [2:0] CFG_DECAY    = 3'd5;
	localparam logic [2:0] CFG_RELATIVE = 3'd6;

	// register reset values
	localparam logic [30:0] RST_DTC   = 31'd16777216;
	localparam logic [24:0] RST_FMIN  = 25'd4194304;
	localparam logic [30:0] RST_GAIN  = 31'd1678;

	// largest value of the rate field
	localparam logic [24:0] RATE_MAX = 25'h1FFFFFF;

	localparam logic signed [33:0] S32_MAX_34 = 34'sd2147483647;
	localparam logic signed [33:0] S32_MIN_34 = -34'sd2147483648;

	// input word: one simulation tick
	typedef struct packed {
		logic signed [31:0] synaptic_current;
		logic signed [31:0] external_current;
		logic signed [31:0] adapter_current;
		logic signed [31:0] noise_voltage;
	} req_word_t;

	// result word
	typedef struct packed {
		logic signed [31:0] membrane_out;
		logic signed [31:0] threshold_out;
		logic signed [31:0] total_current;
		logic        [24:0] firing_rate;
	} rsp_word_t;

	// configuration register set
	typedef struct packed {
		logic        [30:0] dt_over_capacitance;
		logic        [30:0] leak_conductance;
		logic signed [31:0] base_threshold;
		logic        [24:0] min_frequency;
		logic        [30:0] frequency_gain;
		logic        [24:0] accom_decay;
		logic        [24:0] relative_accom;
	} cfg_t;

	// sign extension of a 32-bit value to the sum width
	function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
		return {{2{x[31]}}, x};
	endfunction

	// saturate an exact sum to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX_34) begin
			r = 32'sh7FFFFFFF;
		end else if (x < S32_MIN_34) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/frns_cfg.sv =====
// frns_cfg: configuration register file of the neuron step unit.
// Depends on frns_pkg for the register set type and indexes.
`default_nettype none

module frns_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_addr,
	input  wire logic [31:0]   cfg_wdata,
	output frns_pkg::cfg_t     cfg
);
	import frns_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dt_over_capacitance <= RST_DTC;
			cfg_q.leak_conductance    <= '0;
			cfg_q.base_threshold      <= '0;
			cfg_q.min_frequency       <= RST_FMIN;
			cfg_q.frequency_gain      <= RST_GAIN;
			cfg_q.accom_decay         <= '0;
			cfg_q.relative_accom      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DTC:      cfg_q.dt_over_capacitance <= cfg_wdata[30:0];
				CFG_LEAK:     cfg_q.leak_conductance    <= cfg_wdata[30:0];
				CFG_BASE:     cfg_q.base_threshold      <= cfg_wdata;
				CFG_FMIN:     cfg_q.min_frequency       <= cfg_wdata[24:0];
				CFG_GAIN:     cfg_q.frequency_gain      <= cfg_wdata[30:0];
				CFG_DECAY:    cfg_q.accom_decay         <= cfg_wdata[24:0];
				CFG_RELATIVE: cfg_q.relative_accom      <= cfg_wdata[24:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/frns_mul.sv =====
// frns_mul: shared fixed-point multiplier, 33x33 signed with registered product,
// floor shift by the fraction width and 32-bit saturation. Depends on nothing.
`default_nettype none

module frns_mul #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      prod_shr,
	output logic signed [31:0]      prod_sat
);
	logic signed [65:0] prod_q;
	logic               fits;

	// exact product, one register
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	// arithmetic shift rounds toward minus infinity
	assign prod_shr = prod_q >>> FRAC_BITS;

	// in range when the bits above bit 31 all copy the sign
	assign fits = (prod_shr[65:31] == '0) || (prod_shr[65:31] == '1);

	always_comb begin
		if (fits) begin
			prod_sat = prod_shr[31:0];
		end else if (prod_shr[65]) begin
			prod_sat = 32'sh80000000;
		end else begin
			prod_sat = 32'sh7FFFFFFF;
		end
	end

endmodule

`default_nettype wire

// ===== design/firing_rate_neuron_step_unit.sv =====
// firing_rate_neuron_step_unit: top level, sequencer and datapath registers.
// Depends on frns_pkg, frns_cfg and frns_mul.
//
// Usage: each word on the req channel (valid/ready) is one simulation tick
// with the three input currents and a noise sample. The unit updates its
// membrane voltage and threshold and returns one word on the rsp channel
// with the new voltage, threshold, saturated total current and firing rate.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle; a
// write of the base threshold also reloads the threshold state.
// Sequencing: all products go through one shared 33x33 multiplier, each as a
// product register step followed by a shift, saturate and accumulate step.
// The drift and pull products are skipped with accommodation off, and the
// rate product when the voltage is below threshold. req_ready is high only
// in the idle state, so a new word is taken only after the previous one ends.
// The result sits in an output register; the next word can be accepted while
// it waits. If the receiver stalls past the next word's computation, the
// sequencer holds in its final state until the register is free.
// Reset: voltage and threshold clear to zero, registers take their defaults,
// no result is pending.
`default_nettype none

module firing_rate_neuron_step_unit #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire frns_pkg::req_word_t req_data,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output frns_pkg::rsp_word_t      rsp_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_addr,
	input  wire logic [31:0]         cfg_wdata
);
	import frns_pkg::*;

	localparam logic signed [32:0] ONE_33 = 33'sd1 <<< FRAC_BITS;
	localparam logic signed [65:0] ONE_66 = 66'sd1 <<< FRAC_BITS;
	// largest rate r with r * 1000000 below one
	localparam longint RATE_SMALL = ((longint'(1) << FRAC_BITS) - 1) / 1000000;
	localparam logic signed [65:0] RATE_SMALL_66 = 66'(RATE_SMALL);
	localparam logic signed [65:0] RATE_MAX_66 = 66'(RATE_MAX);

	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_M_LEAK  = 15'b000000000000010,
		ST_D_LEAK  = 15'b000000000000100,
		ST_M_DV    = 15'b000000000001000,
		ST_D_DV    = 15'b000000000010000,
		ST_M_DRIFT = 15'b000000000100000,
		ST_D_DRIFT = 15'b000000001000000,
		ST_M_PULL1 = 15'b000000010000000,
		ST_D_PULL1 = 15'b000000100000000,
		ST_M_PULL2 = 15'b000001000000000,
		ST_D_PULL2 = 15'b000010000000000,
		ST_CMP     = 15'b000100000000000,
		ST_M_RATE  = 15'b001000000000000,
		ST_D_RATE  = 15'b010000000000000,
		ST_FIN     = 15'b100000000000000
	} state_t;

	cfg_t   cfg;
	state_t state_q, state_d;

	// neuron state
	logic signed [31:0] v_q, th_q;

	// working registers of one tick
	logic signed [31:0] total_q, noise_q, diff_q, vn_q, drift_q, pr_q, th_new_q;
	logic signed [32:0] tb_q, od_q, vt_q;
	logic        [24:0] rate_q;

	// output register
	rsp_word_t rsp_q;
	logic      rsp_valid_q;

	logic               accept, load_rsp;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_shr;
	logic signed [31:0] prod_sat;
	logic signed [65:0] rsum, rclip;
	logic        [24:0] rate_d;

	frns_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	frns_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk      (clk),
		.a        (mul_a),
		.b        (mul_b),
		.prod_shr (prod_shr),
		.prod_sat (prod_sat)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_rsp  = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);

	// multiplier operand selection
	always_comb begin
		unique case (state_q)
			ST_M_LEAK: begin
				mul_a = {v_q[31], v_q};
				mul_b = {2'b00, cfg.leak_conductance};
			end
			ST_M_DV: begin
				mul_a = {2'b00, cfg.dt_over_capacitance};
				mul_b = {diff_q[31], diff_q};
			end
			ST_M_DRIFT: begin
				mul_a = tb_q;
				mul_b = {8'b0, cfg.accom_decay};
			end
			ST_M_PULL1: begin
				mul_a = {8'b0, cfg.relative_accom};
				mul_b = {vn_q[31], vn_q};
			end
			ST_M_PULL2: begin
				mul_a = {pr_q[31], pr_q};
				mul_b = od_q;
			end
			ST_M_RATE: begin
				mul_a = {2'b00, cfg.frequency_gain};
				mul_b = vt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rate: offset, clip at one, flush tiny rates, fit the field
	always_comb begin
		rsum = prod_shr + 66'(cfg.min_frequency);
		rclip = (rsum > ONE_66) ? ONE_66 : rsum;
		if (rclip <= RATE_SMALL_66) begin
			rate_d = '0;
		end else if (rclip > RATE_MAX_66) begin
			rate_d = RATE_MAX;
		end else begin
			rate_d = rclip[24:0];
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept) state_d = ST_M_LEAK;
			ST_M_LEAK:  state_d = ST_D_LEAK;
			ST_D_LEAK:  state_d = ST_M_DV;
			ST_M_DV:    state_d = ST_D_DV;
			ST_D_DV:    state_d = (cfg.relative_accom != '0) ? ST_M_DRIFT : ST_CMP;
			ST_M_DRIFT: state_d = ST_D_DRIFT;
			ST_D_DRIFT: state_d = ST_M_PULL1;
			ST_M_PULL1: state_d = ST_D_PULL1;
			ST_D_PULL1: state_d = ST_M_PULL2;
			ST_M_PULL2: state_d = ST_D_PULL2;
			ST_D_PULL2: state_d = ST_CMP;
			ST_CMP:     state_d = (vn_q < th_new_q) ? ST_FIN : ST_M_RATE;
			ST_M_RATE:  state_d = ST_D_RATE;
			ST_D_RATE:  state_d = ST_FIN;
			ST_FIN:     if (load_rsp) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control and neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_q         <= '0;
			th_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				v_q         <= vn_q;
				th_q        <= th_new_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// base threshold write reloads the threshold
			if (cfg_we && (cfg_addr == CFG_BASE)) begin
				th_q <= cfg_wdata;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			total_q <= sat34(sx34(req_data.synaptic_current) + sx34(req_data.external_current)
				+ sx34(req_data.adapter_current));
			noise_q <= req_data.noise_voltage;
			tb_q    <= {th_q[31], th_q} - {cfg.base_threshold[31], cfg.base_threshold};
			od_q    <= ONE_33 - $signed({8'b0, cfg.accom_decay});
		end
		unique case (state_q)
			ST_D_LEAK: diff_q <= sat34(sx34(total_q) - sx34(prod_sat));
			ST_D_DV: begin
				vn_q     <= sat34(sx34(v_q) + sx34(noise_q) + sx34(prod_sat));
				th_new_q <= cfg.base_threshold;
			end
			ST_D_DRIFT: drift_q <= prod_sat;
			ST_D_PULL1: pr_q <= prod_sat;
			ST_D_PULL2: th_new_q <= sat34(sx34(cfg.base_threshold) + sx34(drift_q)
				+ sx34(prod_sat));
			ST_CMP: begin
				vt_q   <= {vn_q[31], vn_q} - {th_new_q[31], th_new_q};
				rate_q <= '0;
			end
			ST_D_RATE: rate_q <= rate_d;
			default: ;
		endcase
		if (load_rsp) begin
			rsp_q.membrane_out  <= vn_q;
			rsp_q.threshold_out <= th_new_q;
			rsp_q.total_current <= total_q;
			rsp_q.firing_rate   <= rate_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// a word is taken only from idle, so ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("req_ready high in the cycle after an accept");

	// a nonzero rate needs the voltage at or above threshold
	a_rate_above_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.firing_rate != '0)) |->
		(rsp_data.membrane_out >= rsp_data.threshold_out))
		else $error("nonzero rate below threshold");

	// rate never above one
	a_rate_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ($signed({41'b0, rsp_data.firing_rate}) <= ONE_66))
		else $error("rate above one");

	// without accommodation the threshold is the base value
	a_no_accom: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp && (cfg.relative_accom == '0)) |=>
		(rsp_data.threshold_out == cfg.base_threshold))
		else $error("threshold moved with accommodation off");

endmodule

`default_nettype wire

// ===== bench/frns_checker.sv =====
// frns_checker: watches the tick, result and register ports of the firing-rate
// neuron step unit, predicts every result word and compares it field by field.
// Depends on frns_pkg.

module frns_checker #(
	parameter int FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  frns_pkg::req_word_t req_data,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  frns_pkg::rsp_word_t rsp_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata,
	output int unsigned         outputs_due,
	output int unsigned         mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import frns_pkg::*;

	localparam longint ONE = longint'(1) << FRAC_BITS;

	cfg_t               regs;
	logic signed [31:0] membrane_v;
	logic signed [31:0] threshold_v;
	rsp_word_t          neuron_outputs_due[$];
	int unsigned        ticks_checked;
	int unsigned        fail_count;

	// saturate an exact value to 32 bits
	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// fixed-point product, floored to the fraction then saturated
	function automatic logic signed [31:0] qmul(input longint a, input longint b);
		return clamp32((a * b) >>> FRAC_BITS);
	endfunction

	// one Euler tick of the neuron; updates voltage and threshold state
	function automatic rsp_word_t advance_neuron(input req_word_t w);
		rsp_word_t          r;
		logic signed [31:0] total;
		logic signed [31:0] diff;
		logic signed [31:0] dv;
		logic signed [31:0] vn;
		logic signed [31:0] th;
		longint             base;
		longint             decay;
		longint             drift;
		longint             pull;
		longint             rate;

		total = clamp32(longint'($signed(w.synaptic_current))
			+ longint'($signed(w.external_current))
			+ longint'($signed(w.adapter_current)));
		diff = clamp32(longint'(total)
			- longint'(qmul(longint'(membrane_v), longint'(regs.leak_conductance))));
		dv = qmul(longint'(regs.dt_over_capacitance), longint'(diff));
		vn = clamp32(longint'(membrane_v) + longint'($signed(w.noise_voltage))
			+ longint'(dv));

		// accommodation: threshold relaxes toward base plus a share of the voltage
		if (regs.relative_accom == '0) begin
			th = $signed(regs.base_threshold);
		end else begin
			base = longint'($signed(regs.base_threshold));
			decay = longint'(regs.accom_decay);
			drift = longint'(qmul(longint'(threshold_v) - base, decay));
			pull = longint'(qmul(longint'(qmul(longint'(regs.relative_accom),
				longint'(vn))), ONE - decay));
			th = clamp32(base + drift + pull);
		end

		// rate: zero below threshold, clipped at one, tiny rates forced to zero
		if (vn < th) begin
			rate = 0;
		end else begin
			rate = ((longint'(regs.frequency_gain) * (longint'(vn) - longint'(th)))
				>>> FRAC_BITS) + longint'(regs.min_frequency);
			if (rate > ONE) begin
				rate = ONE;
			end
			if (rate * 1000000 < ONE) begin
				rate = 0;
			end
			if (rate > longint'(RATE_MAX)) begin
				rate = longint'(RATE_MAX);
			end
		end

		membrane_v = vn;
		threshold_v = th;
		r.membrane_out = vn;
		r.threshold_out = th;
		r.total_current = total;
		r.firing_rate = rate[24:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;

		if (!arst_n) begin
			regs.dt_over_capacitance = RST_DTC;
			regs.leak_conductance = '0;
			regs.base_threshold = '0;
			regs.min_frequency = RST_FMIN;
			regs.frequency_gain = RST_GAIN;
			regs.accom_decay = '0;
			regs.relative_accom = '0;
			membrane_v = '0;
			threshold_v = '0;
			neuron_outputs_due.delete();
			ticks_checked = 0;
			fail_count = 0;
		end else begin
			// register writes; a base threshold write also reloads the threshold
			if (cfg_we) begin
				case (cfg_addr)
					CFG_DTC: regs.dt_over_capacitance = cfg_wdata[30:0];
					CFG_LEAK: regs.leak_conductance = cfg_wdata[30:0];
					CFG_BASE: begin
						regs.base_threshold = cfg_wdata;
						threshold_v = cfg_wdata;
					end
					CFG_FMIN: regs.min_frequency = cfg_wdata[24:0];
					CFG_GAIN: regs.frequency_gain = cfg_wdata[30:0];
					CFG_DECAY: regs.accom_decay = cfg_wdata[24:0];
					CFG_RELATIVE: regs.relative_accom = cfg_wdata[24:0];
					default: ; // unmapped index, nothing changes
				endcase
			end

			// result word against the oldest prediction
			if (rsp_valid && rsp_ready) begin
				if (neuron_outputs_due.size() == 0) begin
					report_mismatch($sformatf("result word %h with none outstanding",
						rsp_data));
				end else begin
					want = neuron_outputs_due.pop_front();
					if (rsp_data.membrane_out !== want.membrane_out) begin
						report_mismatch($sformatf("tick %0d membrane_out %0d, expected %0d",
							ticks_checked, $signed(rsp_data.membrane_out),
							$signed(want.membrane_out)));
					end
					if (rsp_data.threshold_out !== want.threshold_out) begin
						report_mismatch($sformatf("tick %0d threshold_out %0d, expected %0d",
							ticks_checked, $signed(rsp_data.threshold_out),
							$signed(want.threshold_out)));
					end
					if (rsp_data.total_current !== want.total_current) begin
						report_mismatch($sformatf("tick %0d total_current %0d, expected %0d",
							ticks_checked, $signed(rsp_data.total_current),
							$signed(want.total_current)));
					end
					if (rsp_data.firing_rate !== want.firing_rate) begin
						report_mismatch($sformatf("tick %0d firing_rate %0d, expected %0d",
							ticks_checked, rsp_data.firing_rate, want.firing_rate));
					end
					ticks_checked++;
				end
			end

			// accepted tick word
			if (req_valid && req_ready) begin
				neuron_outputs_due.push_back(advance_neuron(req_data));
			end
		end

		outputs_due <= neuron_outputs_due.size();
		mismatches <= fail_count;
	end

endmodule

// ===== bench/firing_rate_neuron_step_unit_test.sv =====
// firing_rate_neuron_step_unit_test: drives ticks and register writes into the
// firing-rate neuron step unit under several idling modes and gives the verdict.
// Depends on frns_pkg, frns_checker and the unit itself.

module firing_rate_neuron_step_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import frns_pkg::*;

	localparam int FRAC_BITS = 24;
	localparam int unsigned LIMIT_CYCLES = 500000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int TICKS_PER_PHASE = 150;

	// index with no register behind it
	localparam logic [2:0] CFG_SPARE = 3'd7;

	localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
	localparam logic signed [31:0] Q_MINUS_FOUR = -32'sh0400_0000;

	typedef enum int {
		SET_LIFELIKE,
		SET_ALL_MAX,
		SET_ALL_ZERO,
		SET_BASE_MIN
	} setting_kind_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_word_t   req_data = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_word_t   rsp_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	int unsigned outputs_due;
	int unsigned mismatches;
	int unsigned cycles = 0;
	int unsigned ticks_sent = 0;
	int unsigned settings_applied = 0;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;

	firing_rate_neuron_step_unit #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	frns_checker #(
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.outputs_due(outputs_due),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// random value in [-span, span]
	function automatic logic signed [31:0] spread(input int unsigned span);
		return 32'($urandom_range(2 * span)) - 32'(span);
	endfunction

	function automatic req_word_t pick_tick();
		req_word_t w;
		if ($urandom_range(9) == 0) begin
			w = {$urandom, $urandom, $urandom, $urandom};
		end else begin
			w.synaptic_current = spread(32'h0100_0000);
			w.external_current = spread(32'h0080_0000);
			w.adapter_current = spread(32'h0080_0000);
			w.noise_voltage = ($urandom_range(1) == 0) ? '0 : spread(32'h000C_CCCD);
		end
		return w;
	endfunction

	function automatic cfg_t pick_setting(input setting_kind_t kind);
		cfg_t s;
		s.dt_over_capacitance = 31'($urandom_range(32'h0100_0000));
		s.leak_conductance = 31'($urandom_range(32'h0200_0000));
		s.base_threshold = spread(32'h0200_0000);
		s.min_frequency = 25'($urandom_range(32'h0100_0000));
		s.frequency_gain = 31'($urandom_range(32'h0800_0000));
		s.accom_decay = 25'($urandom_range(32'h0100_0000));
		s.relative_accom = ($urandom_range(3) == 0) ? '0
			: 25'($urandom_range(32'h0100_0000));
		case (kind)
			SET_ALL_MAX: begin
				s = '1;
				s.base_threshold = S_MAX;
			end
			SET_ALL_ZERO: s = '0;
			SET_BASE_MIN: s.base_threshold = S_MIN;
			default: ;
		endcase
		return s;
	endfunction

	// one tick word; valid stays up into the next word unless a gap is drawn
	task automatic send_tick(input req_word_t w);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req_data <= w;
		do @(posedge clk); while (!req_ready);
		ticks_sent++;
	endtask

	// park the tick channel and wait for every outstanding result
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outputs_due != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// whole register set, with junk in the unused upper bits
	task automatic apply_setting(input cfg_t s);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(CFG_DTC, {junk[31], s.dt_over_capacitance});
		write_reg(CFG_LEAK, {junk[30], s.leak_conductance});
		write_reg(CFG_BASE, s.base_threshold);
		write_reg(CFG_FMIN, {junk[31:25], s.min_frequency});
		write_reg(CFG_GAIN, {junk[29], s.frequency_gain});
		write_reg(CFG_DECAY, {junk[24:18], s.accom_decay});
		write_reg(CFG_RELATIVE, {junk[17:11], s.relative_accom});
		write_reg(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	initial begin
		setting_kind_t kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero tick, saturating sums and noise extremes
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
		send_tick(req_word_t'{S_MAX, S_MAX, S_MAX, 32'sd0});
		send_tick(req_word_t'{S_MIN, S_MIN, S_MIN, 32'sd0});
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, S_MAX});
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, S_MIN});
		send_tick(req_word_t'{S_MAX, S_MIN, 32'sd0, 32'sd0});
		drain();

		// leak and accommodation on: climb over the threshold, then fall back
		write_reg(CFG_DTC, 32'h0020_0000);
		write_reg(CFG_LEAK, 32'h0080_0000);
		write_reg(CFG_BASE, 32'h0080_0000);
		write_reg(CFG_FMIN, 32'h0000_0000);
		write_reg(CFG_GAIN, 32'h0200_0000);
		write_reg(CFG_DECAY, 32'h00C0_0000);
		write_reg(CFG_RELATIVE, 32'h0080_0000);
		cfg_we <= 1'b0;
		settings_applied++;
		repeat (6) send_tick(req_word_t'{Q_ONE, Q_ONE, Q_ONE, 32'sd0});
		repeat (3) send_tick(req_word_t'{Q_MINUS_FOUR, Q_MINUS_FOUR, 32'sd0, 32'sd0});
		drain();

		// accommodation off with decay left set; rate below one in a million
		write_reg(CFG_RELATIVE, 32'h0000_0000);
		write_reg(CFG_BASE, 32'h0000_0000);
		write_reg(CFG_GAIN, 32'h0000_0000);
		write_reg(CFG_FMIN, 32'd5);
		cfg_we <= 1'b0;
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, S_MAX});
		drain();

		// smallest rate that survives
		write_reg(CFG_FMIN, 32'd17);
		cfg_we <= 1'b0;
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
		drain();

		// rate clipped at one; spare index must change nothing
		write_reg(CFG_GAIN, 32'hFFFF_FFFF);
		write_reg(CFG_FMIN, 32'h01FF_FFFF);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		send_tick(req_word_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
		send_tick(req_word_t'{Q_ONE, 32'sd0, 32'sd0, 32'sd0});

		// random phases, each under its own setting and idling mode
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			kind = (p == 1) ? SET_ALL_MAX : (p == 3) ? SET_ALL_ZERO
				: (p == 5) ? SET_BASE_MIN : SET_LIFELIKE;
			apply_setting(pick_setting(kind));
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 63;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 63;
				end
				default: begin
					sender_idle_pct = 23;
					receiver_stall_pct = 23;
				end
			endcase
			repeat (TICKS_PER_PHASE) send_tick(pick_tick());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d tick words over %0d register settings, four idling modes",
			ticks_sent, settings_applied);
		$display("settings included all-ones, all-zero and most-negative base threshold");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/frns_pkg.sv
design/frns_cfg.sv
design/frns_mul.sv
design/firing_rate_neuron_step_unit.sv
bench/frns_checker.sv
bench/firing_rate_neuron_step_unit_test.sv
